>>> hw/rtl/v3a_pkg.sv
// Shared types and constants for the three-component vector unit.
package v3a_pkg;

    localparam int MODE_W      = 3;
    localparam int DATA_W      = 32;
    localparam int IN_DATA_W   = 7 * DATA_W;
    localparam int OUT_DATA_W  = 4 * DATA_W;
    localparam int SQRT_STAGES = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD       = 3'd0,
        MODE_SUB       = 3'd1,
        MODE_SCALE     = 3'd2,
        MODE_LENGTH    = 3'd3,
        MODE_NORMALIZE = 3'd4,
        MODE_DOT       = 3'd5,
        MODE_CROSS     = 3'd6
    } t_mode;

    // Data that rides alongside the square root and divide pipelines.
    typedef struct packed {
        t_mode                  mode;
        logic [2:0][DATA_W-1:0] res;
        logic [DATA_W-1:0]      sc;
        logic                   ovf;
        logic [2:0]             neg;
        logic [2:0][DATA_W-1:0] mag;
    } t_side;

endpackage

>>> hw/rtl/v3a_isqrt.sv
// Fully pipelined 64-bit integer square root, one result bit per stage.
module v3a_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_radicand,
    output logic [31:0] o_root
);
    import v3a_pkg::*;

    logic [63:0] r_n [0:SQRT_STAGES-1];
    logic [63:0] r_r [0:SQRT_STAGES-1];
    logic [63:0] n_in [0:SQRT_STAGES-1];
    logic [63:0] r_in [0:SQRT_STAGES-1];

    assign n_in[0] = i_radicand;
    assign r_in[0] = 64'd0;

    genvar j;
    generate
        for (j = 0; j < SQRT_STAGES; j++) begin : g_stage
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
            logic [63:0] trial;

            if (j > 0) begin : g_link
                assign n_in[j] = r_n[j-1];
                assign r_in[j] = r_r[j-1];
            end

            assign trial = r_in[j] + BIT;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (n_in[j] >= trial) begin
                        r_n[j] <= n_in[j] - trial;
                        r_r[j] <= (r_in[j] >> 1) + BIT;
                    end else begin
                        r_n[j] <= n_in[j];
                        r_r[j] <= r_in[j] >> 1;
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_r[SQRT_STAGES-1][31:0];

endmodule

>>> hw/rtl/v3a_qdiv.sv
// Pipelined restoring divider for a dividend no larger than the divisor.
module v3a_qdiv #(
    parameter int QBITS = 17
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [31:0]      i_dividend,
    input  logic [31:0]      i_divisor,
    output logic [QBITS-1:0] o_quot
);
    logic [32:0]      r_rem [0:QBITS-1];
    logic [QBITS-1:0] r_quo [0:QBITS-1];
    logic [31:0]      r_dvs [0:QBITS-1];

    genvar k;
    generate
        for (k = 0; k < QBITS; k++) begin : g_stage
            logic [32:0]      rin;
            logic [31:0]      dv;
            logic [QBITS-1:0] qin;
            logic             ge;

            // The first stage yields the integer bit; later stages shift in zeros.
            if (k == 0) begin : g_first
                assign rin = {1'b0, i_dividend};
                assign dv  = i_divisor;
                assign qin = '0;
            end else begin : g_next
                assign rin = {r_rem[k-1][31:0], 1'b0};
                assign dv  = r_dvs[k-1];
                assign qin = r_quo[k-1];
            end

            assign ge = rin >= {1'b0, dv};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? rin - {1'b0, dv} : rin;
                    r_quo[k] <= {qin[QBITS-2:0], ge};
                    r_dvs[k] <= dv;
                end
            end
        end
    endgenerate

    assign o_quot = r_quo[QBITS-1];

endmodule

>>> hw/rtl/vec3_arithmetic_unit.sv
// Three-component signed fixed-point vector unit, top level.
// Each transaction carries an operation in tuser and two vectors plus a scale factor in
// tdata; it yields one transaction with a vector, a scalar and an overflow flag. The
// block takes one transaction every cycle while the output is not held. Every
// operation takes the same path: three stages of operand select, multiply and combine,
// a 32-stage square root, a FRAC_BITS + 1 stage divider for normalize, and the output
// register. While the output transaction is held, the whole pipeline stalls.
module vec3_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, scale_factor
    input  logic [v3a_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // mode
    input  logic [v3a_pkg::MODE_W-1:0]         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // r_x, r_y, r_z, scalar_result
    output logic [v3a_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // overflow
    output logic [0:0]                         o_m_axis_tuser
);
    import v3a_pkg::*;

    localparam int QBITS = FRAC_BITS + 1;
    localparam int DEPTH = SQRT_STAGES + QBITS;
    localparam int VLD_N = 3 + DEPTH + 1;

    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        logic [34:0] hi;
        hi = v[65:31];
        if (hi == '0 || hi == '1) begin
            return {1'b0, v[31:0]};
        end else if (v[65]) begin
            return {1'b1, 32'h8000_0000};
        end else begin
            return {1'b1, 32'h7FFF_FFFF};
        end
    endfunction

    logic en;
    logic [VLD_N-1:0] r_vld;

    assign en              = !r_vld[VLD_N-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[VLD_N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[VLD_N-2:0], i_s_axis_tvalid};
        end
    end

    // Stage 1: operand selection for the six shared multipliers.
    t_mode in_mode;
    logic signed [31:0] in_a [3];
    logic signed [31:0] in_b [3];
    logic signed [31:0] in_s;
    logic signed [31:0] opx [6];
    logic signed [31:0] opy [6];

    assign in_mode = t_mode'(i_s_axis_tuser);
    assign in_a[0] = i_s_axis_tdata[31:0];
    assign in_a[1] = i_s_axis_tdata[63:32];
    assign in_a[2] = i_s_axis_tdata[95:64];
    assign in_b[0] = i_s_axis_tdata[127:96];
    assign in_b[1] = i_s_axis_tdata[159:128];
    assign in_b[2] = i_s_axis_tdata[191:160];
    assign in_s    = i_s_axis_tdata[223:192];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            opx[i] = '0;
            opy[i] = '0;
        end
        case (in_mode)
            MODE_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    opx[i] = in_a[i];
                    opy[i] = in_s;
                end
            end
            MODE_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    opx[i] = in_a[i];
                    opy[i] = in_b[i];
                end
            end
            MODE_LENGTH, MODE_NORMALIZE: begin
                for (int i = 0; i < 3; i++) begin
                    opx[i] = in_a[i];
                    opy[i] = in_a[i];
                end
            end
            MODE_CROSS: begin
                opx[0] = in_a[1]; opy[0] = in_b[2];
                opx[1] = in_a[2]; opy[1] = in_b[0];
                opx[2] = in_a[0]; opy[2] = in_b[1];
                opx[3] = in_a[2]; opy[3] = in_b[1];
                opx[4] = in_a[0]; opy[4] = in_b[2];
                opx[5] = in_a[1]; opy[5] = in_b[0];
            end
            default: begin
            end
        endcase
    end

    t_mode              r_m1, r_m2, r_m3;
    logic signed [31:0] r_a1 [3];
    logic signed [31:0] r_b1 [3];
    logic signed [31:0] r_x1 [6];
    logic signed [31:0] r_y1 [6];
    logic signed [31:0] r_a2 [3];
    logic signed [31:0] r_b2 [3];
    logic signed [63:0] r_p2 [6];
    logic signed [31:0] r_a3 [3];
    logic signed [65:0] r_w3 [4];
    logic               r_sh3;
    logic [63:0]        r_sq3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1 <= in_mode;
            for (int i = 0; i < 3; i++) begin
                r_a1[i] <= in_a[i];
                r_b1[i] <= in_b[i];
            end
            for (int i = 0; i < 6; i++) begin
                r_x1[i] <= opx[i];
                r_y1[i] <= opy[i];
            end
        end
    end

    // Stage 2: products.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2 <= r_m1;
            for (int i = 0; i < 3; i++) begin
                r_a2[i] <= r_a1[i];
                r_b2[i] <= r_b1[i];
            end
            for (int i = 0; i < 6; i++) begin
                r_p2[i] <= r_x1[i] * r_y1[i];
            end
        end
    end

    // Stage 3: exact sums and differences in a wide word.
    logic signed [65:0] n_w3 [4];
    logic               n_sh3;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_w3[i] = '0;
        end
        n_sh3 = 1'b0;
        case (r_m2)
            MODE_ADD: begin
                for (int i = 0; i < 3; i++) begin
                    n_w3[i] = 66'(r_a2[i]) + 66'(r_b2[i]);
                end
            end
            MODE_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    n_w3[i] = 66'(r_a2[i]) - 66'(r_b2[i]);
                end
            end
            MODE_SCALE: begin
                n_sh3 = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    n_w3[i] = 66'(r_p2[i]);
                end
            end
            MODE_DOT: begin
                n_sh3   = 1'b1;
                n_w3[3] = 66'(r_p2[0]) + 66'(r_p2[1]) + 66'(r_p2[2]);
            end
            MODE_CROSS: begin
                n_sh3 = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    n_w3[i] = 66'(r_p2[i]) - 66'(r_p2[i+3]);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m3  <= r_m2;
            r_sh3 <= n_sh3;
            for (int i = 0; i < 3; i++) begin
                r_a3[i] <= r_a2[i];
            end
            for (int i = 0; i < 4; i++) begin
                r_w3[i] <= n_w3[i];
            end
            // Squares are never negative, so the sum fits in 64 unsigned bits.
            r_sq3 <= $unsigned(r_p2[0]) + $unsigned(r_p2[1]) + $unsigned(r_p2[2]);
        end
    end

    // Stage 4: fixed-point shift and saturation; result enters the side line.
    t_side side_in;
    logic [32:0] sat [4];
    logic signed [65:0] shv [4];

    always_comb begin
        side_in.mode = r_m3;
        side_in.ovf  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            shv[i] = r_sh3 ? (r_w3[i] >>> FRAC_BITS) : r_w3[i];
            sat[i] = sat32(shv[i]);
            side_in.ovf = side_in.ovf | sat[i][32];
        end
        for (int i = 0; i < 3; i++) begin
            side_in.res[i] = sat[i][31:0];
            side_in.neg[i] = r_a3[i][31];
            side_in.mag[i] = r_a3[i][31] ? (~r_a3[i] + 32'd1) : r_a3[i];
        end
        side_in.sc = sat[3][31:0];
    end

    t_side r_side [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= side_in;
            for (int k = 1; k < DEPTH; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    logic [31:0] root;

    v3a_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_radicand (r_sq3),
        .o_root     (root)
    );

    logic [31:0] r_root [0:QBITS-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_root[0] <= root;
            for (int k = 1; k < QBITS; k++) begin
                r_root[k] <= r_root[k-1];
            end
        end
    end

    logic [QBITS-1:0] quot [3];

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_div
            v3a_qdiv #(
                .QBITS (QBITS)
            ) u_qdiv (
                .i_clk      (i_clk),
                .i_en       (en),
                .i_dividend (r_side[SQRT_STAGES-1].mag[g]),
                .i_divisor  (root),
                .o_quot     (quot[g])
            );
        end
    endgenerate

    // Output stage: length and normalize results join the rest here.
    t_side       fin;
    logic [31:0] fin_root;
    logic [31:0] q32;
    logic [31:0] n_res [3];
    logic [31:0] n_sc;
    logic        n_ovf;
    logic [31:0] r_res [3];
    logic [31:0] r_sc;
    logic        r_ovf;

    assign fin      = r_side[DEPTH-1];
    assign fin_root = r_root[QBITS-1];

    always_comb begin
        q32 = '0;
        for (int i = 0; i < 3; i++) begin
            n_res[i] = fin.res[i];
        end
        n_sc  = fin.sc;
        n_ovf = fin.ovf;
        case (fin.mode)
            MODE_LENGTH: begin
                n_ovf = fin_root[31];
                n_sc  = fin_root[31] ? 32'h7FFF_FFFF : fin_root;
            end
            MODE_NORMALIZE: begin
                // A zero-length vector normalizes to zero.
                for (int i = 0; i < 3; i++) begin
                    q32 = 32'(quot[i]);
                    if (fin_root == '0) begin
                        n_res[i] = '0;
                    end else begin
                        n_res[i] = fin.neg[i] ? (~q32 + 32'd1) : q32;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_res[i] <= n_res[i];
            end
            r_sc  <= n_sc;
            r_ovf <= n_ovf;
        end
    end

    assign o_m_axis_tdata = {r_sc, r_res[2], r_res[1], r_res[0]};
    assign o_m_axis_tuser = r_ovf;

endmodule
